[rtl/core/ertp_pkg.sv]
// ============================================================================
// ertp_pkg: shared constants, types and functions of the point transform
// Holds the default widths, the CORDIC gain and the arctangent table.
// ============================================================================
package ertp_pkg;

   localparam int COORD_WIDTH_DEF     = 32;
   localparam int ANGLE_WIDTH_DEF     = 16;
   localparam int TRIG_ITERATIONS_DEF = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int TRIG_WIDTH   = 34;

   localparam logic signed [TRIG_WIDTH-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

   typedef logic signed [TRIG_WIDTH-1:0] trig_type;
   typedef logic signed [32:0]           phase_type;

   function automatic phase_type atan_entry(input int idx);
      logic [31:0] v;
      begin
         case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
         endcase
         return phase_type'({1'b0, v});
      end
   endfunction

endpackage

[rtl/core/ertp_rot_stage.sv]
// ============================================================================
// ertp_rot_stage: one plane rotation with Q1.30 products
// Computes a*c - b*s and a*s + b*c over three registered steps, advancing
// together with the rest of the pipeline.
// ============================================================================
module ertp_rot_stage #(
   parameter int IN_WIDTH  = 34,
   parameter int OUT_WIDTH = 36
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic signed [IN_WIDTH-1:0]  a,
   input  logic signed [IN_WIDTH-1:0]  b,
   input  ertp_pkg::trig_type          c,
   input  ertp_pkg::trig_type          s,
   output logic signed [OUT_WIDTH-1:0] p_out,
   output logic signed [OUT_WIDTH-1:0] q_out
);
   import ertp_pkg::*;

   localparam int PW = IN_WIDTH + TRIG_WIDTH;

   // Operands are registered first, then the four products, then the
   // rounded sums.
   logic signed [IN_WIDTH-1:0] a_ff, b_ff;
   trig_type                   c_ff, s_ff;
   logic signed [PW-1:0] ac_ff, bs_ff, as_ff, bc_ff;
   logic signed [PW-1:0] ac_in, bs_in, as_in, bc_in;
   logic signed [OUT_WIDTH-1:0] p_ff, q_ff, p_in, q_in;
   logic signed [PW-1:0] rac, rbs, ras, rbc;
   localparam logic signed [PW-1:0] HALF = PW'(64'sd536870912);

   assign ac_in = PW'(a_ff) * PW'(c_ff);
   assign bs_in = PW'(b_ff) * PW'(s_ff);
   assign as_in = PW'(a_ff) * PW'(s_ff);
   assign bc_in = PW'(b_ff) * PW'(c_ff);

   always_comb begin
      rac  = (ac_ff + HALF) >>> 30;
      rbs  = (bs_ff + HALF) >>> 30;
      ras  = (as_ff + HALF) >>> 30;
      rbc  = (bc_ff + HALF) >>> 30;
      p_in = OUT_WIDTH'(rac - rbs);
      q_in = OUT_WIDTH'(ras + rbc);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= a;
         b_ff  <= b;
         c_ff  <= c;
         s_ff  <= s;
         ac_ff <= ac_in;
         bs_ff <= bs_in;
         as_ff <= as_in;
         bc_ff <= bc_in;
         p_ff  <= p_in;
         q_ff  <= q_in;
      end
   end

   assign p_out = p_ff;
   assign q_out = q_ff;
endmodule

[rtl/core/euler_rotate_translate_point.sv]
// ============================================================================
// euler_rotate_translate_point: pipelined Euler XYZ rotation and translation
// Rotates a Q16.16 point about X, Y then Z and adds an offset, saturating.
// ============================================================================
// The block takes one item per clock while the output is not stalled and
// returns one result item per input item, in order. Sine and cosine of all
// three angles come from three CORDIC pipelines with one register stage per
// iteration. The three rotations each take three stages (operand, product,
// rounded sum), and a final stage adds the offset and saturates. The whole
// pipeline advances together: a stall on the result side holds every stage,
// and an item is taken whenever the last stage is empty or its item leaves.
module euler_rotate_translate_point #(
   parameter int COORD_WIDTH     = ertp_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH     = ertp_pkg::ANGLE_WIDTH_DEF,
   parameter int TRIG_ITERATIONS = ertp_pkg::TRIG_ITERATIONS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_vec_x,
   input  logic signed [COORD_WIDTH-1:0] req_vec_y,
   input  logic signed [COORD_WIDTH-1:0] req_vec_z,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic        [ANGLE_WIDTH-1:0] req_angle_x,
   input  logic        [ANGLE_WIDTH-1:0] req_angle_y,
   input  logic        [ANGLE_WIDTH-1:0] req_angle_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_WIDTH-1:0] rsp_out_x,
   output logic signed [COORD_WIDTH-1:0] rsp_out_y,
   output logic signed [COORD_WIDTH-1:0] rsp_out_z
);
   import ertp_pkg::*;

   localparam int NIT   = (TRIG_ITERATIONS < ATAN_ENTRIES) ? TRIG_ITERATIONS : ATAN_ENTRIES;
   localparam int NSTG  = NIT + 1;   // angle prep plus the iterations
   localparam int LAT   = NSTG + 10; // plus three rotations and the output
   localparam int CW    = COORD_WIDTH;
   localparam int W1    = CW + 2;    // widths of the rotated terms
   localparam int W2    = CW + 3;
   localparam int W3    = CW + 4;

   logic adv;
   logic [LAT-1:0] vld_ff;

   // Every stage moves when the output register is free or being drained.
   assign adv       = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------
   // CORDIC for the three angles, one iteration per stage.
   // ---------------------------------------------------------------------
   trig_type  cx_ff [3][NSTG];
   trig_type  cy_ff [3][NSTG];
   phase_type cz_ff [3][NSTG];
   logic      cn_ff [3][NSTG];
   logic [ANGLE_WIDTH-1:0] ang [3];

   assign ang[0] = req_angle_x;
   assign ang[1] = req_angle_y;
   assign ang[2] = req_angle_z;

   for (genvar k = 0; k < 3; k++) begin : g_trig
      logic [31:0] a_al, a_adj;
      logic        neg;
      assign a_al  = {ang[k], {(32-ANGLE_WIDTH){1'b0}}};
      assign neg   = a_al[31] ^ a_al[30];
      assign a_adj = neg ? (a_al + 32'h80000000) : a_al;

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[k][0] <= CORDIC_GAIN;
            cy_ff[k][0] <= '0;
            cz_ff[k][0] <= phase_type'($signed(a_adj));
            cn_ff[k][0] <= neg;
         end
      end

      for (genvar i = 0; i < NIT; i++) begin : g_it
         trig_type  x_in, y_in, dx, dy;
         phase_type z_in;
         assign dx = cy_ff[k][i] >>> i;
         assign dy = cx_ff[k][i] >>> i;
         always_comb begin
            if (!cz_ff[k][i][32]) begin
               x_in = cx_ff[k][i] - dx;
               y_in = cy_ff[k][i] + dy;
               z_in = cz_ff[k][i] - atan_entry(i);
            end else begin
               x_in = cx_ff[k][i] + dx;
               y_in = cy_ff[k][i] - dy;
               z_in = cz_ff[k][i] + atan_entry(i);
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               cx_ff[k][i+1] <= x_in;
               cy_ff[k][i+1] <= y_in;
               cz_ff[k][i+1] <= z_in;
               cn_ff[k][i+1] <= cn_ff[k][i];
            end
         end
      end
   end

   // Final sign fix of sine and cosine.
   trig_type cs [3];
   trig_type sn [3];
   for (genvar k = 0; k < 3; k++) begin : g_fix
      assign cs[k] = cn_ff[k][NIT] ? -cx_ff[k][NIT] : cx_ff[k][NIT];
      assign sn[k] = cn_ff[k][NIT] ? -cy_ff[k][NIT] : cy_ff[k][NIT];
   end

   // ---------------------------------------------------------------------
   // Coordinates ride along: NSTG stages of delay, then more per rotation.
   // ---------------------------------------------------------------------
   logic signed [CW-1:0] vx_ff [NSTG+3], vy_ff [NSTG], vz_ff [NSTG];
   logic signed [CW-1:0] px_ff [LAT-1], py_ff [LAT-1], pz_ff [LAT-1];
   trig_type c2_ff [3], s2_ff [3], c3_ff [6], s3_ff [6];

   always_ff @(posedge clock) begin
      if (adv) begin
         vx_ff[0] <= req_vec_x;
         vy_ff[0] <= req_vec_y;
         vz_ff[0] <= req_vec_z;
         px_ff[0] <= req_pos_x;
         py_ff[0] <= req_pos_y;
         pz_ff[0] <= req_pos_z;
         for (int j = 1; j < NSTG + 3; j++) begin
            vx_ff[j] <= vx_ff[j-1];
         end
         for (int j = 1; j < LAT - 1; j++) begin
            px_ff[j] <= px_ff[j-1];
            py_ff[j] <= py_ff[j-1];
            pz_ff[j] <= pz_ff[j-1];
         end
         for (int j = 1; j < NSTG; j++) begin
            vy_ff[j] <= vy_ff[j-1];
            vz_ff[j] <= vz_ff[j-1];
         end
         c2_ff[0] <= cs[1];
         s2_ff[0] <= sn[1];
         c3_ff[0] <= cs[2];
         s3_ff[0] <= sn[2];
         for (int j = 1; j < 3; j++) begin
            c2_ff[j] <= c2_ff[j-1];
            s2_ff[j] <= s2_ff[j-1];
         end
         for (int j = 1; j < 6; j++) begin
            c3_ff[j] <= c3_ff[j-1];
            s3_ff[j] <= s3_ff[j-1];
         end
      end
   end

   // Rotation about X: y1 = y*c1 - z*s1, z1 = y*s1 + z*c1.
   logic signed [W1-1:0] y1, z1;
   ertp_rot_stage #(.IN_WIDTH(CW), .OUT_WIDTH(W1)) u_rot_x (
      .clock (clock), .adv (adv),
      .a (vy_ff[NSTG-1]), .b (vz_ff[NSTG-1]),
      .c (cs[0]), .s (sn[0]),
      .p_out (y1), .q_out (z1)
   );

   // Rotation about Y: x2 = x*c2 + z1*s2, z2 = z1*c2 - x*s2.
   // Computed as (z1, x) rotated: p = z1*c2 - x*s2, q = z1*s2 + x*c2.
   logic signed [W2-1:0] z2, x2;
   ertp_rot_stage #(.IN_WIDTH(W1), .OUT_WIDTH(W2)) u_rot_y (
      .clock (clock), .adv (adv),
      .a (z1), .b (W1'(vx_ff[NSTG+2])),
      .c (c2_ff[2]), .s (s2_ff[2]),
      .p_out (z2), .q_out (x2)
   );

   // y1 waits three stages for the Z rotation.
   logic signed [W1-1:0] y1_ff [3];
   logic signed [W2-1:0] z2_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         y1_ff[0] <= y1;
         z2_ff[0] <= z2;
         for (int j = 1; j < 3; j++) begin
            y1_ff[j] <= y1_ff[j-1];
            z2_ff[j] <= z2_ff[j-1];
         end
      end
   end

   // Rotation about Z: x3 = x2*c3 - y1*s3, y3 = x2*s3 + y1*c3.
   logic signed [W3-1:0] x3, y3;
   ertp_rot_stage #(.IN_WIDTH(W2), .OUT_WIDTH(W3)) u_rot_z (
      .clock (clock), .adv (adv),
      .a (x2), .b (W2'(y1_ff[2])),
      .c (c3_ff[5]), .s (s3_ff[5]),
      .p_out (x3), .q_out (y3)
   );

   // Offset add and saturation into the output register.
   localparam int SW = W3 + 1;
   function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] hi, lo;
      begin
         hi = SW'({1'b0, {(CW-1){1'b1}}});
         lo = -hi - SW'(1);
         if (v > hi)      return CW'(hi);
         else if (v < lo) return CW'(lo);
         else             return CW'(v);
      end
   endfunction

   logic signed [CW-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   assign ox_in = sat(SW'(x3) + SW'(px_ff[LAT-2]));
   assign oy_in = sat(SW'(y3) + SW'(py_ff[LAT-2]));
   assign oz_in = sat(SW'(z2_ff[2]) + SW'(pz_ff[LAT-2]));

   always_ff @(posedge clock) begin
      if (adv) begin
         ox_ff <= ox_in;
         oy_ff <= oy_in;
         oz_ff <= oz_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_out_x = ox_ff;
   assign rsp_out_y = oy_ff;
   assign rsp_out_z = oz_ff;
endmodule

[rtl/core/ertp_checker.sv]
// ============================================================================
// ertp_checker: port-level checks of the point transform
// Watches the handshake and the flow of items through the pipeline.
// ============================================================================
module ertp_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall
);
   // The input side stalls only while a result is held back.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // A held result stays shown.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");
endmodule

bind euler_rotate_translate_point ertp_checker u_ertp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

[dv/euler_rotate_translate_point_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point transform testbench
// Sends points, offsets and Euler angles to the rotate-and-translate pipeline.
// Each accepted item is run through a local CORDIC and rotation predictor.
// Every result is compared field by field, in order, with the prediction.
// ----------------------------------------------------------------------------
module euler_rotate_translate_point_test;
   import ertp_pkg::*;

   localparam int CW = ertp_pkg::COORD_WIDTH_DEF;
   localparam int AW = ertp_pkg::ANGLE_WIDTH_DEF;
   localparam int STEPS = (ertp_pkg::TRIG_ITERATIONS_DEF > 24) ? 24 :
                          ertp_pkg::TRIG_ITERATIONS_DEF;
   localparam longint GAIN_Q30 = 64'h26DD3B6A;
   localparam int PIPE_DEPTH = ertp_pkg::TRIG_ITERATIONS_DEF + 11;
   localparam longint CYCLE_LIMIT = 600000;

   // Arctangent steps in units of 2^-32 of a full turn.
   localparam longint ARCTAN_STEP [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
      64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

   typedef struct {
      logic signed [CW-1:0] vec_x, vec_y, vec_z;
      logic signed [CW-1:0] pos_x, pos_y, pos_z;
      logic [AW-1:0] angle_x, angle_y, angle_z;
   } point_item_type;

   typedef struct {
      logic signed [CW-1:0] out_x, out_y, out_z;
   } moved_point_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [CW-1:0] req_vec_x, req_vec_y, req_vec_z;
   logic signed [CW-1:0] req_pos_x, req_pos_y, req_pos_z;
   logic [AW-1:0] req_angle_x, req_angle_y, req_angle_z;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [CW-1:0] rsp_out_x, rsp_out_y, rsp_out_z;

   // Points whose transformed result has not come back yet, oldest first.
   moved_point_type predicted_points[$];
   int error_count = 0;
   longint cycle_count = 0;

   // Receiver behavior: a long hold-off requested by a test, random stalls,
   // or a quiet stretch where the receiver never stalls.
   int hold_request = 0;
   int hold_left = 0;
   int stall_burst = 0;
   bit receiver_quiet = 0;
   bit sender_quiet = 0;

   euler_rotate_translate_point dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vec_x(req_vec_x), .req_vec_y(req_vec_y), .req_vec_z(req_vec_z),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z)
   );

   initial clock = 0;
   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Sine and cosine in Q1.30 from a rotation-mode CORDIC. The angle is folded
   // into the right half-plane by adding half a turn, and the signs of both
   // results are flipped back at the end.
   function automatic void cordic_sin_cos(input logic [AW-1:0] angle,
                                          output longint cos_q30,
                                          output longint sin_q30);
      logic [31:0] turn;
      bit flip;
      longint x, y, z, dx, dy;
      begin
         turn = 32'(angle) << (32 - AW);
         flip = turn[31] ^ turn[30];
         if (flip) begin
            turn = turn + 32'h80000000;
         end
         z = longint'($signed(turn));
         x = GAIN_Q30;
         y = 0;
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - ARCTAN_STEP[i];
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + ARCTAN_STEP[i];
            end
         end
         cos_q30 = flip ? -x : x;
         sin_q30 = flip ? -y : y;
      end
   endfunction

   // Exact product, rounded half up back to the coordinate scale.
   function automatic longint scale_q30(input longint coord, input longint trig);
      logic signed [127:0] wide_c, wide_t, prod;
      begin
         wide_c = coord;
         wide_t = trig;
         prod = wide_c * wide_t + (128'sd1 <<< 29);
         return longint'(prod >>> 30);
      end
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input longint v);
      longint hi, lo;
      begin
         hi = (longint'(1) <<< (CW - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi[CW-1:0];
         if (v < lo) return lo[CW-1:0];
         return v[CW-1:0];
      end
   endfunction

   function automatic moved_point_type predict_transform(input point_item_type p);
      longint c1, s1, c2, s2, c3, s3;
      longint y1, z1, x2, z2, x3, y3;
      moved_point_type r;
      begin
         cordic_sin_cos(p.angle_x, c1, s1);
         cordic_sin_cos(p.angle_y, c2, s2);
         cordic_sin_cos(p.angle_z, c3, s3);
         // X rotation, then Y, then Z; intermediate sums are not clamped.
         y1 = scale_q30(p.vec_y, c1) - scale_q30(p.vec_z, s1);
         z1 = scale_q30(p.vec_y, s1) + scale_q30(p.vec_z, c1);
         x2 = scale_q30(p.vec_x, c2) + scale_q30(z1, s2);
         z2 = scale_q30(z1, c2) - scale_q30(p.vec_x, s2);
         x3 = scale_q30(x2, c3) - scale_q30(y1, s3);
         y3 = scale_q30(x2, s3) + scale_q30(y1, c3);
         r.out_x = clamp_coord(x3 + longint'(p.pos_x));
         r.out_y = clamp_coord(y3 + longint'(p.pos_y));
         r.out_z = clamp_coord(z2 + longint'(p.pos_z));
         return r;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [CW-1:0] got,
                                  input logic [CW-1:0] want);
      begin
         $display("MISMATCH at cycle %0d: %s got %h expected %h",
                  cycle_count, what, got, want);
         error_count++;
      end
   endtask

   // Mostly back-to-back or short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      begin
         r = $urandom_range(0, 99);
         if (r < 60) return 0;
         if (r < 92) return $urandom_range(1, 3);
         return $urandom_range(8, 40);
      end
   endfunction

   // Offers one item and holds it until the pipeline takes it. A following
   // item with no gap keeps valid high, so valid is never dropped and raised
   // in the same step.
   task automatic send_point(input point_item_type p);
      int gap;
      begin
         req_valid   <= 1'b1;
         req_vec_x   <= p.vec_x;
         req_vec_y   <= p.vec_y;
         req_vec_z   <= p.vec_z;
         req_pos_x   <= p.pos_x;
         req_pos_y   <= p.pos_y;
         req_pos_z   <= p.pos_z;
         req_angle_x <= p.angle_x;
         req_angle_y <= p.angle_y;
         req_angle_z <= p.angle_z;
         do @(posedge clock); while (req_stall);
         predicted_points.push_back(predict_transform(p));
         gap = sender_quiet ? 0 : idle_length();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic end_burst();
      begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      begin
         while (predicted_points.size() != 0) @(posedge clock);
      end
   endtask

   function automatic logic signed [CW-1:0] rand_coord();
      int r;
      begin
         r = $urandom_range(0, 9);
         if (r < 5) return $signed($urandom());
         // Small magnitudes keep many results away from saturation.
         if (r < 9) return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
         return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      end
   endfunction

   function automatic logic [AW-1:0] rand_angle();
      int r;
      begin
         r = $urandom_range(0, 9);
         if (r < 8) return AW'($urandom());
         // Near the quadrant boundaries, where the half-turn fold changes.
         return AW'($urandom_range(0, 3) * (1 << (AW - 2)) +
                    $urandom_range(0, 4) - 2);
      end
   endfunction

   function automatic point_item_type rand_point();
      point_item_type p;
      begin
         p.vec_x = rand_coord();
         p.vec_y = rand_coord();
         p.vec_z = rand_coord();
         p.pos_x = rand_coord();
         p.pos_y = rand_coord();
         p.pos_z = rand_coord();
         p.angle_x = rand_angle();
         p.angle_y = rand_angle();
         p.angle_z = rand_angle();
         return p;
      end
   endfunction

   function automatic point_item_type make_point(
      input logic signed [CW-1:0] v, input logic signed [CW-1:0] o,
      input logic [AW-1:0] ax, input logic [AW-1:0] ay, input logic [AW-1:0] az);
      point_item_type p;
      begin
         p.vec_x = v;
         p.vec_y = v;
         p.vec_z = v;
         p.pos_x = o;
         p.pos_y = o;
         p.pos_z = o;
         p.angle_x = ax;
         p.angle_y = ay;
         p.angle_z = az;
         return p;
      end
   endfunction

   // Coordinate extremes and offsets that push every axis into saturation.
   task automatic test_coord_extremes();
      begin
         send_point(make_point(0, 0, 0, 0, 0));
         send_point(make_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 0));
         send_point(make_point(32'sh80000000, 32'sh80000000, 0, 0, 0));
         send_point(make_point(32'sh7FFFFFFF, 32'sh80000000, 16'h2000, 16'h2000, 16'h2000));
         send_point(make_point(32'sh80000000, 32'sh7FFFFFFF, 16'hE000, 16'h6000, 16'hA000));
         send_point(make_point(32'sh00010000, 32'sh7FFF0000, 16'h1234, 16'h5678, 16'h9ABC));
         send_point(make_point(-32'sh00010000, 32'sh80010000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
         send_point(make_point(32'sh80000000, 0, 16'h8000, 16'h8000, 16'h8000));
         end_burst();
      end
   endtask

   // Quarter turns, half turns and angles just beside every quadrant
   // boundary, so the half-turn fold is exercised in both directions.
   task automatic test_quadrant_angles();
      logic [AW-1:0] corner [10];
      point_item_type p;
      begin
         corner = '{16'h0000, 16'h0001, 16'h3FFF, 16'h4000, 16'h4001,
                    16'h7FFF, 16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
         foreach (corner[i]) begin
            p = make_point(32'sh00030000, 32'sh00001000, corner[i],
                           corner[(i + 3) % 10], corner[(i + 7) % 10]);
            p.vec_y = -32'sh00058000;
            p.vec_z = 32'sh7FFFFFFF;
            send_point(p);
         end
         end_burst();
      end
   endtask

   task automatic test_random_points(input int count);
      begin
         repeat (count) send_point(rand_point());
         end_burst();
      end
   endtask

   // The receiver holds off for a long stretch while items keep coming, so
   // the pipeline fills and stalls its input.
   task automatic test_output_hold_off();
      begin
         sender_quiet = 1;
         hold_request = 3 * PIPE_DEPTH + 40;
         repeat (3 * PIPE_DEPTH) send_point(rand_point());
         sender_quiet = 0;
         end_burst();
      end
   endtask

   // Back-to-back items with no idling on either side.
   task automatic test_full_rate();
      begin
         sender_quiet = 1;
         receiver_quiet = 1;
         repeat (150) send_point(rand_point());
         end_burst();
         wait_drained();
         sender_quiet = 0;
         receiver_quiet = 0;
      end
   endtask

   // Result side: long hold-off when a test asks for it, no stalls while the
   // receiver is quiet, otherwise bursts of stalls of random length.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_burst > 0) begin
         stall_burst--;
         rsp_stall <= 1'b1;
      end else begin
         stall_burst = idle_length();
         rsp_stall <= (stall_burst > 0);
         if (stall_burst > 0) stall_burst--;
      end
   end

   // Each result that leaves is matched against the oldest prediction.
   always @(posedge clock) begin
      moved_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_points.size() == 0) begin
            $display("UNEXPECTED result at cycle %0d: %h %h %h",
                     cycle_count, rsp_out_x, rsp_out_y, rsp_out_z);
            error_count++;
         end else begin
            want = predicted_points.pop_front();
            if (rsp_out_x !== want.out_x) report_mismatch("out_x", rsp_out_x, want.out_x);
            if (rsp_out_y !== want.out_y) report_mismatch("out_y", rsp_out_y, want.out_y);
            if (rsp_out_z !== want.out_z) report_mismatch("out_z", rsp_out_z, want.out_z);
         end
      end
   end

   // Watchdog on a hung handshake.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_vec_x = '0;
      req_vec_y = '0;
      req_vec_z = '0;
      req_pos_x = '0;
      req_pos_y = '0;
      req_pos_z = '0;
      req_angle_x = '0;
      req_angle_y = '0;
      req_angle_z = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_coord_extremes();
      test_quadrant_angles();
      test_random_points(500);
      // The sender pauses here until every result is back.
      wait_drained();
      test_output_hold_off();
      test_full_rate();
      test_random_points(700);

      wait_drained();
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (error_count == 0 && predicted_points.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
